// File: rtl/core/sorted_key_table_insert_lookup_macros.svh
// Assertion macros for the sorted key table core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SORTED_KEY_TABLE_INSERT_LOOKUP_MACROS_SVH
`define SORTED_KEY_TABLE_INSERT_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SKT_ASSERT_HOLD(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SKT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sktbl_pkg.sv
// Shared types and codes for the sorted key table core.
// Used by sktbl_seq and the top level; no dependencies.
`timescale 1ns / 1ps

package sktbl_pkg;

    // Command codes (code three is unused and ignored)
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_CLEAR  = 2'd2
    } sktbl_func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } sktbl_status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT,
        ST_WRITE,
        ST_DN_RD,
        ST_DN_CMP,
        ST_UP_RD,
        ST_UP_CMP
    } sktbl_state_t;

    // Command word
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [1:0]  info_kind;
        logic [31:0] payload;
    } sktbl_cmd_t;

    // Result word
    typedef struct packed {
        sktbl_status_t status;
        logic [7:0]    position;
        logic [31:0]   found_payload;
        logic [8:0]    entry_count;
    } sktbl_rsp_t;

    // One table entry as held in memory
    typedef struct packed {
        logic [31:0] key;
        logic [1:0]  kind;
        logic [31:0] payload;
    } sktbl_entry_t;

    // Completion from the sequencer to the output register
    typedef struct packed {
        logic       valid;
        sktbl_rsp_t rsp;
    } sktbl_fin_t;

endpackage

// File: rtl/core/sktbl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sktbl_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/sktbl_seq.sv
// Sorted key table sequencer: binary search, shift-up insert, lookup scan, clear.
// Depends on sktbl_pkg and the assertion macro header; drives one entry RAM.
`timescale 1ns / 1ps
`include "sorted_key_table_insert_lookup_macros.svh"

module sktbl_seq
    import sktbl_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  sktbl_cmd_t                     cmd,
    output logic                           busy,
    output sktbl_fin_t                     fin,
    output logic                           mem_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
    output sktbl_entry_t                   mem_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
    input  sktbl_entry_t                   mem_rdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_DEPTH);

    sktbl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;      // exclusive upper bound
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;    // shift destination or scan index
    logic [CNT_W-1:0]   slot_reg, slot_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]   wr_addr_reg, wr_addr_next;
    logic               lookup_reg, lookup_next;
    logic [31:0]        key_reg, key_next;
    logic [1:0]         kind_reg, kind_next;
    logic [31:0]        data_reg, data_next;

    logic               rd_use;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid_ext;
    logic               key_gt;
    logic               key_lt;
    logic [CNT_W-1:0]   lo_try;
    logic [CNT_W-1:0]   hi_try;

    // Low bits of an index or count for the result fields
    function automatic logic [7:0] low8(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[7:0];
    endfunction

    function automatic logic [8:0] low9(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[8:0];
    endfunction

    // Probe arithmetic: floor midpoint of the open window, compare with read key
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1;
    assign mid_ext = CNT_W'(mid_reg);
    assign key_gt  = key_reg > mem_rdata.key;
    assign key_lt  = key_reg < mem_rdata.key;
    assign lo_try  = key_gt ? (mid_ext + 1'b1) : lo_reg;
    assign hi_try  = key_lt ? mid_ext : hi_reg;

    assign busy = (state_reg != ST_IDLE);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        ptr_reg     <= ptr_next;
        slot_reg    <= slot_next;
        wr_addr_reg <= wr_addr_next;
        lookup_reg  <= lookup_next;
        key_reg     <= key_next;
        kind_reg    <= kind_next;
        data_reg    <= data_next;
    end

    // Next state, memory access and completion
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        ptr_next     = ptr_reg;
        slot_next    = slot_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;
        lookup_next  = lookup_reg;
        key_next     = key_reg;
        kind_next    = kind_reg;
        data_next    = data_reg;

        mem_we       = 1'b0;
        mem_waddr    = wr_addr_reg;
        mem_wdata    = mem_rdata;
        mem_raddr    = mid_sum[IDX_W:1];
        rd_use       = 1'b0;

        fin                   = '0;
        fin.rsp.status        = STAT_OK;
        fin.rsp.entry_count   = low9(count_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next    = cmd.key;
                    kind_next   = cmd.info_kind;
                    data_next   = cmd.payload;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    slot_next   = '0;
                    lookup_next = (cmd.func == FN_LOOKUP);
                    case (cmd.func)
                        FN_INSERT:
                        begin
                            if (count_reg >= CNT_MAX)
                            begin
                                fin.valid      = 1'b1;
                                fin.rsp.status = STAT_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        FN_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                fin.valid      = 1'b1;
                                fin.rsp.status = STAT_MISS;
                            end
                            else
                            begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        FN_CLEAR:
                        begin
                            count_next          = '0;
                            fin.valid           = 1'b1;
                            fin.rsp.entry_count = '0;
                        end
                        default:
                        begin
                            fin.valid = 1'b1;
                        end
                    endcase
                end
            end

            // Issue the probe read at the midpoint
            ST_SRCH_RD:
            begin
                mem_raddr  = mid_sum[IDX_W:1];
                mid_next   = mid_sum[IDX_W:1];
                rd_use     = 1'b1;
                state_next = ST_SRCH_CMP;
            end

            // Narrow the window or stop
            ST_SRCH_CMP:
            begin
                if ((key_gt || key_lt) && (lo_try < hi_try))
                begin
                    lo_next    = lo_try;
                    hi_next    = hi_try;
                    state_next = ST_SRCH_RD;
                end
                else if (lookup_reg)
                begin
                    if (!key_gt && !key_lt)
                    begin
                        ptr_next   = mid_ext;
                        state_next = ST_DN_RD;
                    end
                    else
                    begin
                        fin.valid      = 1'b1;
                        fin.rsp.status = STAT_MISS;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    slot_next    = key_gt ? (mid_ext + 1'b1) : mid_ext;
                    ptr_next     = count_reg;
                    wr_pend_next = 1'b0;
                    state_next   = ST_SHIFT;
                end
            end

            // Move entries up one slot: read i-1 now, write it to i next cycle
            ST_SHIFT:
            begin
                if (wr_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg > slot_reg)
                begin
                    mem_raddr    = IDX_W'(ptr_reg - 1'b1);
                    rd_use       = 1'b1;
                    wr_pend_next = 1'b1;
                    wr_addr_next = IDX_W'(ptr_reg);
                    ptr_next     = ptr_reg - 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    state_next   = ST_WRITE;
                end
            end

            // Store the new entry at its slot
            ST_WRITE:
            begin
                mem_we                = 1'b1;
                mem_waddr             = IDX_W'(slot_reg);
                mem_wdata.key         = key_reg;
                mem_wdata.kind        = kind_reg;
                mem_wdata.payload     = data_reg;
                count_next            = count_reg + 1'b1;
                fin.valid             = 1'b1;
                fin.rsp.position      = low8(slot_reg);
                fin.rsp.entry_count   = low9(count_reg + 1'b1);
                state_next            = ST_IDLE;
            end

            // Walk down to the first entry with an equal key
            ST_DN_RD:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = ST_UP_RD;
                end
                else
                begin
                    mem_raddr  = IDX_W'(ptr_reg - 1'b1);
                    rd_use     = 1'b1;
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_CMP:
            begin
                if (mem_rdata.key == key_reg)
                begin
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = ST_DN_RD;
                end
                else
                begin
                    state_next = ST_UP_RD;
                end
            end

            // Walk up through equal keys looking for a matching kind
            ST_UP_RD:
            begin
                if (ptr_reg >= count_reg)
                begin
                    fin.valid      = 1'b1;
                    fin.rsp.status = STAT_MISS;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    mem_raddr  = IDX_W'(ptr_reg);
                    rd_use     = 1'b1;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                if (mem_rdata.key != key_reg)
                begin
                    fin.valid      = 1'b1;
                    fin.rsp.status = STAT_MISS;
                    state_next     = ST_IDLE;
                end
                else if (mem_rdata.kind == kind_reg)
                begin
                    fin.valid             = 1'b1;
                    fin.rsp.position      = low8(ptr_reg);
                    fin.rsp.found_payload = mem_rdata.payload;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_UP_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    `SKT_ASSERT_HOLD(a_no_rw_clash, clk, rst_n, mem_we && rd_use, mem_waddr != mem_raddr, "shift read and write hit the same entry")
    `SKT_ASSERT_HOLD(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_MAX, "entry count above table depth")
    `SKT_ASSERT_NEXT(a_clear_empties, clk, rst_n, start && !busy && cmd.func == FN_CLEAR, count_reg == '0, "clear did not empty table")
    `SKT_ASSERT_HOLD(a_search_window, clk, rst_n, state_reg == ST_SRCH_RD, lo_reg < hi_reg, "probe issued with empty window")
    `SKT_ASSERT_HOLD(a_shift_floor, clk, rst_n, state_reg == ST_SHIFT, ptr_reg >= slot_reg, "shift pointer passed insert slot")

endmodule

// File: rtl/core/sorted_key_table_insert_lookup.sv
// Sorted key table: insert with binary search and shift, lookup, clear.
// Usage:
//   Raise start with a command word on cmd; it is taken at a rising edge where
//   busy is low. Exactly one result word follows on rsp, marked by done for a
//   single cycle. The receiver has no back-pressure; done is a pure strobe.
//   A new command may be started in the same cycle its predecessor's done shows.
// Command flow from accept to done:
//   clear, unused code, full-table insert, empty-table lookup: from idle.
//   insert into an empty table: no search, the entry is written. Otherwise
//   binary probes (at most clog2(TABLE_DEPTH) probes), then each entry above
//   the slot is moved up one place, then the new entry is written.
//   lookup: binary probes, then a walk down and up through equal-key entries
//   to a matching kind; a key that is not held answers after the probes.
// The entry RAM has one read and one write port with a registered read; the
// probe loop reads and then compares each entry, and the shift walk reads one
// entry while it writes the one read before. One command is in work at a time.
// Reset empties the table at once (entry count to zero); no RAM sweep is needed.
// Depends on sktbl_pkg, sktbl_seq and sktbl_ram.
`timescale 1ns / 1ps

module sorted_key_table_insert_lookup
    import sktbl_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  sktbl_cmd_t cmd,
    output logic       busy,
    output logic       done,
    output sktbl_rsp_t rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int ENT_W = $bits(sktbl_entry_t);

    sktbl_fin_t         fin;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    sktbl_entry_t       mem_wdata;
    sktbl_entry_t       mem_rdata;
    logic [ENT_W-1:0]   ram_rdata;
    logic               done_reg;
    sktbl_rsp_t         rsp_reg;

    sktbl_seq #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .fin       (fin),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sktbl_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (ENT_W'(mem_wdata)),
        .raddr (mem_raddr),
        .rdata (ram_rdata)
    );

    assign mem_rdata = sktbl_entry_t'(ram_rdata);

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
        end
    end

    // Result word register, loaded on completion
    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            rsp_reg <= fin.rsp;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
